// ----- rtl/bm3_pkg.sv -----
// bm3_pkg: shared constants, codes and types for the 3x3 box mean filter.
// Used by bm3_front, bm3_queue, bm3_back and box_mean_3x3_edge_aware.
package bm3_pkg;

  // Fixed register widths
  localparam int GRID_W_BITS   = 11;
  localparam int GRID_H_BITS   = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Reset values of the size registers
  localparam logic [GRID_W_BITS-1:0] GRID_W_RESET = 11'd64;
  localparam logic [GRID_H_BITS-1:0] GRID_H_RESET = 16'd64;

  // Register index, taken from the word address bit of paddr
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Input item kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // Neighbour count (1..9) and divider step grouping
  localparam int CNT_BITS        = 4;
  localparam int STEPS_PER_STAGE = 4;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QLVL_BITS   = 3;

  // Which window rows/columns lie inside the grid for one output
  typedef struct packed {
    logic use_top;
    logic use_bot;
    logic use_left;
    logic use_right;
  } mask_t;

  // Per-result control handed to the divider
  typedef struct packed {
    logic [CNT_BITS-1:0] cnt;
    logic                last;
  } job_t;

  // Number of in-grid neighbours: rows in use times columns in use
  function automatic logic [CNT_BITS-1:0] neigh_count(input mask_t m);
    logic [1:0] rows;
    logic [1:0] cols;
    rows = 2'd1 + {1'b0, m.use_top} + {1'b0, m.use_bot};
    cols = 2'd1 + {1'b0, m.use_left} + {1'b0, m.use_right};
    return {2'b00, rows} * {2'b00, cols};
  endfunction

endpackage

// ----- rtl/bm3_front.sv -----
// bm3_front: accepts samples, tracks raster positions, holds the line buffers
// and the 3x3 window, and forms the masked neighbour sum of each result.
// Depends on bm3_pkg.
module bm3_front
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [GRID_W_BITS-1:0]        grid_width,
  input  logic [GRID_H_BITS-1:0]        grid_height,
  input  logic                          restart,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [QLVL_BITS-1:0]          q_level,
  output logic                          push,
  output logic signed [SAMPLE_BITS+3:0] push_sum,
  output job_t                          push_job
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 2);
  localparam int WC    = (EW > GRID_W_BITS) ? EW : GRID_W_BITS;
  localparam int SUM_W = SAMPLE_BITS + 4;
  localparam int LB_W  = 2 * SAMPLE_BITS;

  // Effective sizes
  logic [WC-1:0]          gw_ext;
  logic [WC-1:0]          eff_w_c;
  logic [EW-1:0]          eff_w;
  logic [EW-1:0]          w_plus1;
  logic [COL_W-1:0]       last_col;
  logic [GRID_H_BITS-1:0] eff_h;
  logic [GRID_H_BITS-1:0] last_row;

  always_comb begin
    gw_ext = WC'(grid_width);
    if (gw_ext == '0) begin
      eff_w_c = WC'(1);
    end else if (gw_ext > WC'(MAX_WIDTH)) begin
      eff_w_c = WC'(MAX_WIDTH);
    end else begin
      eff_w_c = gw_ext;
    end
  end

  assign eff_w    = eff_w_c[EW-1:0];
  assign w_plus1  = eff_w + EW'(1);
  assign last_col = COL_W'(eff_w - EW'(1));
  assign eff_h    = (grid_height == '0) ? GRID_H_BITS'(1) : grid_height;
  assign last_row = eff_h - GRID_H_BITS'(1);

  // Position state
  logic [COL_W-1:0]       in_col_r;
  logic [GRID_H_BITS-1:0] in_row_r;
  logic [COL_W-1:0]       out_col_r;
  logic [GRID_H_BITS-1:0] out_row_r;
  logic [EW-1:0]          seen_r;

  // Stage 1 (line buffer read returned) and stage 2 (window ready)
  logic                          s1_v_r;
  logic [COL_W-1:0]              s1_addr_r;
  logic signed [SAMPLE_BITS-1:0] s1_val_r;
  logic                          s1_emit_r;
  mask_t                         s1_mask_r;
  job_t                          s1_job_r;
  logic                          s2_v_r;
  mask_t                         s2_mask_r;
  job_t                          s2_job_r;

  // Credit check: every item in flight may need a queue slot
  logic [QLVL_BITS:0] inflight;
  assign inflight = {1'b0, q_level} + (QLVL_BITS+1)'(s1_v_r) + (QLVL_BITS+1)'(s2_v_r);
  assign in_ready = inflight < (QLVL_BITS+1)'(QUEUE_DEPTH);

  // Classification of the incoming item
  logic                          draining;
  logic                          take;
  logic signed [SAMPLE_BITS-1:0] val;
  logic                          emit;
  logic                          col_wrap;
  mask_t                         mask;
  logic                          frame_end;

  assign draining  = in_row_r >= eff_h;
  assign take      = in_valid && in_ready && (draining || (in_cmd == CMD_SAMPLE));
  assign val       = draining ? '0 : in_sample;
  assign emit      = seen_r >= w_plus1;
  assign col_wrap  = in_col_r == last_col;
  assign mask.use_top   = out_row_r != '0;
  assign mask.use_bot   = out_row_r != last_row;
  assign mask.use_left  = out_col_r != '0;
  assign mask.use_right = out_col_r != last_col;
  assign frame_end = !mask.use_bot && !mask.use_right;

  // Raster counters; the last result of a frame restarts them
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      seen_r    <= '0;
    end else if (take) begin
      if (emit && frame_end) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        seen_r    <= '0;
      end else begin
        in_col_r <= col_wrap ? '0 : in_col_r + COL_W'(1);
        if (col_wrap && !draining) begin
          in_row_r <= in_row_r + GRID_H_BITS'(1);
        end
        if (!emit) begin
          seen_r <= seen_r + EW'(1);
        end else if (!mask.use_right) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + GRID_H_BITS'(1);
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // Line buffers: upper row in the high half, middle row in the low half
  logic [LB_W-1:0]               lb_mem [MAX_WIDTH];
  logic [LB_W-1:0]               rd_q_r;
  logic                          byp_v_r;
  logic [LB_W-1:0]               byp_d_r;
  logic [LB_W-1:0]               lb_data;
  logic signed [SAMPLE_BITS-1:0] s1_top;
  logic signed [SAMPLE_BITS-1:0] s1_mid;

  assign lb_data = byp_v_r ? byp_d_r : rd_q_r;
  assign s1_top  = lb_data[LB_W-1:SAMPLE_BITS];
  assign s1_mid  = lb_data[SAMPLE_BITS-1:0];

  // Read at accept, write back in the following cycle (rows move up by one)
  always_ff @(posedge clk) begin
    if (take) begin
      rd_q_r <= lb_mem[in_col_r];
    end
    if (s1_v_r) begin
      lb_mem[s1_addr_r] <= {s1_mid, s1_val_r};
    end
  end

  // Forward the pending write when the next item hits the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else begin
      byp_v_r <= take && s1_v_r && (s1_addr_r == in_col_r);
    end
  end

  always_ff @(posedge clk) begin
    byp_d_r <= {s1_mid, s1_val_r};
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r     <= in_col_r;
      s1_val_r      <= val;
      s1_emit_r     <= emit;
      s1_mask_r     <= mask;
      s1_job_r.cnt  <= neigh_count(mask);
      s1_job_r.last <= emit && frame_end;
    end
    if (s1_v_r) begin
      s2_mask_r <= s1_mask_r;
      s2_job_r  <= s1_job_r;
    end
  end

  // 3x3 window: columns oldest to newest, rows top/mid/new
  logic signed [SAMPLE_BITS-1:0] win_r    [9];
  logic signed [SAMPLE_BITS-1:0] win_base [9];
  logic signed [SAMPLE_BITS-1:0] win_nxt  [9];
  logic                          clr_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      win_base[k] = clr_r ? '0 : win_r[k];
    end
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]   = win_base[i*3+1];
      win_nxt[i*3+1] = win_base[i*3+2];
    end
    win_nxt[2] = s1_top;
    win_nxt[5] = s1_mid;
    win_nxt[8] = s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  // Window clears lazily on the next shift after a frame restart
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      clr_r <= 1'b1;
    end else if (s1_v_r) begin
      clr_r <= s1_emit_r && s1_job_r.last;
    end
  end

  // Masked neighbour sum of the window
  logic [2:0]               row_use;
  logic [2:0]               col_use;
  logic signed [SUM_W-1:0]  sum;

  assign row_use = {s2_mask_r.use_bot, 1'b1, s2_mask_r.use_top};
  assign col_use = {s2_mask_r.use_right, 1'b1, s2_mask_r.use_left};

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_use[i] && col_use[j]) begin
          sum = sum + SUM_W'(win_r[i*3+j]);
        end
      end
    end
  end

  assign push     = s2_v_r;
  assign push_sum = sum;
  assign push_job = s2_job_r;

  // Warm-up counter saturates at one row plus one sample
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= w_plus1)
    else $error("warm-up count beyond width plus one");

  // Frame end puts the raster back to its start
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && emit && frame_end && !restart |=>
      in_col_r == '0 && in_row_r == '0 && out_row_r == '0 && seen_r == '0)
    else $error("frame did not restart after its last result");

endmodule

// ----- rtl/bm3_queue.sv -----
// bm3_queue: short show-ahead job queue between front and back.
// Depends on bm3_pkg.
module bm3_queue
  import bm3_pkg::*;
#(
  parameter int W = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [W-1:0]         push_data,
  input  logic                 pop,
  output logic [W-1:0]         head_data,
  output logic                 nempty,
  output logic [QLVL_BITS-1:0] level
);

  logic [W-1:0]           slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r;
  logic [QPTR_BITS-1:0]   rd_ptr_r;
  logic [QLVL_BITS-1:0]   level_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + QLVL_BITS'(1);
      end else if (pop && !push) begin
        level_r <= level_r - QLVL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = slot_r[rd_ptr_r];
  assign nempty    = level_r != '0;
  assign level     = level_r;

  // Front's credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> level_r != QLVL_BITS'(QUEUE_DEPTH))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> level_r != '0)
    else $error("job queue underflow");

endmodule

// ----- rtl/bm3_back.sv -----
// bm3_back: pipelined divide of the neighbour sum by the neighbour count,
// truncating toward zero, with the output register. Depends on bm3_pkg.
module bm3_back
  import bm3_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_nempty,
  input  logic signed [SAMPLE_BITS+3:0] q_sum,
  input  job_t                          q_job,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        out_mean,
  output logic                          out_last
);

  localparam int SUM_W = SAMPLE_BITS + 4;
  localparam int ABS_W = SAMPLE_BITS + 3;
  localparam int NSTG  = (ABS_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_W = NSTG * STEPS_PER_STAGE;

  // Restoring division state: remainder, dividend shifting out / quotient in
  typedef struct packed {
    logic [CNT_BITS-1:0] rem;
    logic [DIV_W-1:0]    qd;
    logic [CNT_BITS-1:0] cnt;
    logic                neg;
    logic                last;
  } dstage_t;

  function automatic dstage_t div_steps(input dstage_t s);
    dstage_t           r;
    logic [CNT_BITS:0] part;
    r = s;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      part = {r.rem, r.qd[DIV_W-1]};
      r.qd = {r.qd[DIV_W-2:0], 1'b0};
      if (part >= {1'b0, r.cnt}) begin
        r.rem   = CNT_BITS'(part - {1'b0, r.cnt});
        r.qd[0] = 1'b1;
      end else begin
        r.rem = part[CNT_BITS-1:0];
      end
    end
    return r;
  endfunction

  // Magnitude and sign of the incoming sum
  logic [SUM_W-1:0] mag;
  dstage_t          seed;

  assign mag       = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
  assign seed.rem  = '0;
  assign seed.qd   = DIV_W'(mag[ABS_W-1:0]);
  assign seed.cnt  = q_job.cnt;
  assign seed.neg  = q_sum[SUM_W-1];
  assign seed.last = q_job.last;

  // Whole pipeline moves unless the output register is held
  logic            adv;
  logic [NSTG-1:0] st_v_r;
  dstage_t         st_r [NSTG];
  logic            out_v_r;
  logic [SAMPLE_BITS-1:0] out_mean_r;
  logic            out_last_r;
  logic [DIV_W-1:0] quot_signed;

  assign adv   = !out_v_r || out_ready;
  assign q_pop = adv && q_nempty;

  assign quot_signed = st_r[NSTG-1].neg ? (~st_r[NSTG-1].qd + DIV_W'(1)) : st_r[NSTG-1].qd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      st_v_r  <= {st_v_r[NSTG-2:0], q_nempty};
      out_v_r <= st_v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_steps(seed);
      for (int k = 1; k < NSTG; k++) begin
        st_r[k] <= div_steps(st_r[k-1]);
      end
      out_mean_r <= quot_signed[SAMPLE_BITS-1:0];
      out_last_r <= st_r[NSTG-1].last;
    end
  end

  assign out_valid = out_v_r;
  assign out_mean  = out_mean_r;
  assign out_last  = out_last_r;

  // A finished division leaves a remainder below the divisor
  a_rem_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r[NSTG-1] |-> st_r[NSTG-1].rem < st_r[NSTG-1].cnt)
    else $error("divider remainder not below neighbour count");

  // A popped job enters the first divider stage
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_v_r[0])
    else $error("popped job lost before the divider");

endmodule

// ----- rtl/box_mean_3x3_edge_aware.sv -----
// box_mean_3x3_edge_aware: streaming edge-aware 3x3 mean over a raster grid.
// Path: accept, stage 1, stage 2, job queue, divider st_r[0..NSTG-1], output register,
//   NSTG = ceil((SAMPLE_BITS+3)/4); a position's result follows the item width+1 later.
// Throughput: one item per cycle when in_tready is high, set by one line buffer read/write.
// Reset: synchronous; grid 64x64, positions and window cleared, line buffers not
//   cleared (no clearing pass); the block accepts items once reset is released.
module box_mean_3x3_edge_aware
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [TDATA_W-1:0]       in_tdata,     // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic                     in_tuser,     // [0] command
  // mean output stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [TDATA_W-1:0]       out_tdata,    // [SAMPLE_BITS-1:0] mean_value, rest zero
  output logic                     out_tlast,    // frame_last
  // register port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam int SUM_W = SAMPLE_BITS + 4;
  localparam int QW    = SUM_W + $bits(job_t);

  // Size registers
  logic [GRID_W_BITS-1:0] grid_width_r;
  logic [GRID_H_BITS-1:0] grid_height_r;
  logic                   cfg_wr;
  logic                   reg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[CFG_ADDR_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_W_RESET;
      grid_height_r <= GRID_H_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_pwdata[GRID_W_BITS-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_pwdata[GRID_H_BITS-1:0];
        default:         grid_width_r  <= grid_width_r;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_sel)
      REG_GRID_WIDTH:  cfg_prdata = CFG_DATA_BITS'(grid_width_r);
      REG_GRID_HEIGHT: cfg_prdata = CFG_DATA_BITS'(grid_height_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Front: positions, line buffers, window and sum
  logic                    push;
  logic signed [SUM_W-1:0] push_sum;
  job_t                    push_job;
  logic [QLVL_BITS-1:0]    q_level;

  bm3_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .restart     (cfg_wr),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .q_level     (q_level),
    .push        (push),
    .push_sum    (push_sum),
    .push_job    (push_job)
  );

  // Job queue
  logic [QW-1:0] head_data;
  logic          q_nempty;
  logic          q_pop;

  bm3_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_sum, push_job}),
    .pop       (q_pop),
    .head_data (head_data),
    .nempty    (q_nempty),
    .level     (q_level)
  );

  // Back: divider and output register
  logic [SAMPLE_BITS-1:0] out_mean;

  bm3_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_sum     ($signed(head_data[QW-1 -: SUM_W])),
    .q_job     (job_t'(head_data[$bits(job_t)-1:0])),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mean  (out_mean),
    .out_last  (out_tlast)
  );

  assign out_tdata = TDATA_W'(out_mean);

endmodule
